>>> sv/lcl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcl_pkg
// Shared types, constants and helpers of the LC ladder line step block.
// ----------------------------------------------------------------------------
package lcl_pkg;

  localparam int SEGMENTS = 16;
  localparam int AW       = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
  localparam int CNT_W    = $clog2(SEGMENTS + 1);

  localparam int DATA_W    = 32;
  localparam int SAMPLE_W  = 16;
  localparam int CFG_IDX_W = 2;
  localparam int SUM_W     = 50;
  localparam int PROD_W    = 64;

  localparam logic [AW-1:0] LAST_IDX = AW'(SEGMENTS - 1);

  localparam logic [DATA_W-1:0] IND_GAIN_RST     = 32'h0001_0000;
  localparam logic [DATA_W-1:0] SER_RES_RST      = 32'h0000_0000;
  localparam logic [DATA_W-1:0] CAP_GAIN_RST     = 32'h0001_0000;
  localparam logic [DATA_W-1:0] END_CAP_GAIN_RST = 32'h0001_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INDUCTOR_GAIN      = 2'd0,
    REG_SERIES_RESISTANCE  = 2'd1,
    REG_CAPACITOR_GAIN     = 2'd2,
    REG_END_CAPACITOR_GAIN = 2'd3
  } lcl_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CUR,
    ST_VOLT,
    ST_DONE
  } lcl_state_e;

  // Clamps a wide signed sum to the signed 32-bit range.
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] x);
    logic [SUM_W-DATA_W:0] top;
    top = x[SUM_W-1:DATA_W-1];
    if ((&top) || !(|top)) begin
      return x[DATA_W-1:0];
    end else if (x[SUM_W-1]) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

  // Drops the 16 fraction bits of a product, rounding toward minus infinity.
  function automatic logic signed [SUM_W-1:0] trunc16(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-17:0] t;
    t = p[PROD_W-1:16];
    return SUM_W'(t);
  endfunction

endpackage

>>> sv/lc_ladder_line_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lc_ladder_line_step
// Fixed-point RLC ladder line advanced one symplectic Euler step per sample.
// ----------------------------------------------------------------------------
// Each input word drives segment zero of the ladder and yields one output word,
// the last node voltage in Q1.15. Node voltages and branch currents live in two
// small synchronous memories. The current pass spaces its segment issues apart
// because it needs the single 33x33 multiplier twice per segment, and the
// voltage pass issues one node per cycle, with a short drain after each pass.
// The next word is taken while the previous result still waits on the output.
module lc_ladder_line_step (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lcl_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [lcl_pkg::DATA_W-1:0]          cfg_wdata_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [lcl_pkg::SAMPLE_W-1:0]        s_axis_tdata,   // [15:0] sample
  input  logic                                s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [lcl_pkg::SAMPLE_W-1:0]        m_axis_tdata,   // [15:0] tap_voltage
  output logic                                m_axis_tlast
);
  import lcl_pkg::*;

  lcl_state_e state_q, state_d;

  logic [DATA_W-1:0] ind_gain_q, ser_res_q, cap_gain_q, end_cap_gain_q;

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             phase_q, phase_d;
  logic             cnt_full;
  logic [AW-1:0]    rd_idx, rd_idx_nx;

  logic accept, c_issue, v_issue, cnt_clr, out_load, out_free;

  logic signed [DATA_W-1:0] src_q;
  logic                     last_q;

  // Memories and their read registers.
  logic [DATA_W-1:0]   vmem [SEGMENTS];
  logic [DATA_W-1:0]   imem [SEGMENTS];
  logic [SEGMENTS-1:0] vmem_ok_q, imem_ok_q;
  logic [DATA_W-1:0]   v_rd_q, i_rda_q, i_rdb_q;
  logic                v_rdok_q, i_rdaok_q, i_rdbok_q;
  logic signed [DATA_W-1:0] v_rd, i_rda, i_rdb;

  // Current pass pipeline.
  logic [4:0]               c_vld_q;
  logic [AW-1:0]            c_tag_q [5];
  logic signed [DATA_W-1:0] vprev_q;
  logic signed [DATA_W:0]   base_q;
  logic signed [SUM_W-1:0]  raw_q;
  logic signed [DATA_W-1:0] d_q;
  logic signed [DATA_W-1:0] i2_q, i3_q, i4_q, i5_q;
  logic signed [DATA_W-1:0] vp;
  logic signed [DATA_W-1:0] new_i;

  // Voltage pass pipeline.
  logic [2:0]               v_vld_q;
  logic [AW-1:0]            v_tag_q [3];
  logic signed [DATA_W-1:0] e_q, vv2_q, vv3_q;
  logic signed [DATA_W-1:0] new_v;
  logic signed [SUM_W-1:0]  inext;

  // Shared multiplier.
  logic signed [DATA_W-1:0] mul_a;
  logic [DATA_W-1:0]        mul_b;
  logic signed [DATA_W:0]   mul_a_x, mul_b_x;
  logic signed [2*DATA_W+1:0] mul_full;
  logic signed [PROD_W-1:0] mul_q;

  // Result.
  logic signed [DATA_W-1:0] vout_q;
  logic signed [DATA_W-1:0] vhalf;
  logic [SAMPLE_W-1:0]      tap;
  logic                     m_tvalid_q, m_tlast_q;
  logic [SAMPLE_W-1:0]      m_tdata_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ind_gain_q     <= IND_GAIN_RST;
      ser_res_q      <= SER_RES_RST;
      cap_gain_q     <= CAP_GAIN_RST;
      end_cap_gain_q <= END_CAP_GAIN_RST;
    end else if (cfg_we_i) begin
      case (lcl_reg_e'(cfg_idx_i))
        REG_INDUCTOR_GAIN:      ind_gain_q     <= cfg_wdata_i;
        REG_SERIES_RESISTANCE:  ser_res_q      <= cfg_wdata_i;
        REG_CAPACITOR_GAIN:     cap_gain_q     <= cfg_wdata_i;
        REG_END_CAPACITOR_GAIN: end_cap_gain_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  assign cnt_full  = (cnt_q == CNT_W'(SEGMENTS));
  assign rd_idx    = cnt_q[AW-1:0];
  assign rd_idx_nx = rd_idx + AW'(1);
  assign out_free  = !m_tvalid_q || m_axis_tready;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) state_d = ST_CUR;
      end
      ST_CUR: begin
        if (cnt_full && !(|c_vld_q)) state_d = ST_VOLT;
      end
      ST_VOLT: begin
        if (cnt_full && !(|v_vld_q)) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    s_axis_tready = 1'b0;
    c_issue       = 1'b0;
    v_issue       = 1'b0;
    cnt_clr       = 1'b0;
    out_load      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        cnt_clr       = s_axis_tvalid;
      end
      ST_CUR: begin
        c_issue = !cnt_full && !phase_q;
        cnt_clr = cnt_full && !(|c_vld_q);
      end
      ST_VOLT: begin
        v_issue = !cnt_full;
      end
      ST_DONE: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  assign accept = s_axis_tvalid && s_axis_tready;

  always_comb begin
    cnt_d   = cnt_q;
    phase_d = phase_q;
    if (cnt_clr) begin
      cnt_d = '0;
    end else if (c_issue || v_issue) begin
      cnt_d = cnt_q + CNT_W'(1);
    end
    if (accept) begin
      phase_d = 1'b0;
    end else if (state_q == ST_CUR) begin
      phase_d = !phase_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      phase_q    <= 1'b0;
      c_vld_q    <= '0;
      v_vld_q    <= '0;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      phase_q <= phase_d;
      c_vld_q <= {c_vld_q[3:0], c_issue};
      v_vld_q <= {v_vld_q[1:0], v_issue};
      if (out_load) begin
        m_tvalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      src_q  <= {{(DATA_W-SAMPLE_W-1){s_axis_tdata[SAMPLE_W-1]}}, s_axis_tdata, 1'b0};
      last_q <= s_axis_tlast;
    end
  end

  // Entry valid bits stand in for the all-zero reset of both memories.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vmem_ok_q <= '0;
      imem_ok_q <= '0;
      v_rdok_q  <= 1'b0;
      i_rdaok_q <= 1'b0;
      i_rdbok_q <= 1'b0;
    end else begin
      if (v_vld_q[2]) vmem_ok_q[v_tag_q[2]] <= 1'b1;
      if (c_vld_q[4]) imem_ok_q[c_tag_q[4]] <= 1'b1;
      v_rdok_q  <= vmem_ok_q[rd_idx];
      i_rdaok_q <= imem_ok_q[rd_idx];
      i_rdbok_q <= imem_ok_q[rd_idx_nx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (v_vld_q[2]) vmem[v_tag_q[2]] <= new_v;
    v_rd_q <= vmem[rd_idx];
  end

  always_ff @(posedge clk_i) begin
    if (c_vld_q[4]) imem[c_tag_q[4]] <= new_i;
    i_rda_q <= imem[rd_idx];
    i_rdb_q <= imem[rd_idx_nx];
  end

  assign v_rd  = v_rdok_q  ? v_rd_q  : '0;
  assign i_rda = i_rdaok_q ? i_rda_q : '0;
  assign i_rdb = i_rdbok_q ? i_rdb_q : '0;

  // The current pass claims the multiplier in its first and fourth stage, the
  // voltage pass in its second stage.
  always_comb begin
    if (c_vld_q[3]) begin
      mul_a = d_q;
      mul_b = ind_gain_q;
    end else if (v_vld_q[1]) begin
      mul_a = e_q;
      mul_b = (v_tag_q[1] == LAST_IDX) ? end_cap_gain_q : cap_gain_q;
    end else begin
      mul_a = i_rda;
      mul_b = ser_res_q;
    end
  end

  assign mul_a_x  = {mul_a[DATA_W-1], mul_a};
  assign mul_b_x  = {1'b0, mul_b};
  assign mul_full = mul_a_x * mul_b_x;

  assign vp    = (c_tag_q[0] == '0) ? src_q : vprev_q;
  assign new_i = sat32(SUM_W'(i5_q) + trunc16(mul_q));
  assign new_v = sat32(SUM_W'(vv3_q) + trunc16(mul_q));
  assign inext = (v_tag_q[0] == LAST_IDX) ? '0 : SUM_W'(i_rdb);

  always_ff @(posedge clk_i) begin
    mul_q <= mul_full[PROD_W-1:0];

    c_tag_q[0] <= rd_idx;
    for (int k = 1; k < 5; k++) begin
      c_tag_q[k] <= c_tag_q[k-1];
    end
    if (c_vld_q[0]) vprev_q <= v_rd;
    base_q <= {vp[DATA_W-1], vp} - {v_rd[DATA_W-1], v_rd};
    i2_q   <= i_rda;
    raw_q  <= SUM_W'(base_q) - trunc16(mul_q);
    i3_q   <= i2_q;
    d_q    <= sat32(raw_q);
    i4_q   <= i3_q;
    i5_q   <= i4_q;

    v_tag_q[0] <= rd_idx;
    v_tag_q[1] <= v_tag_q[0];
    v_tag_q[2] <= v_tag_q[1];
    e_q   <= sat32(SUM_W'(i_rda) - inext);
    vv2_q <= v_rd;
    vv3_q <= vv2_q;

    if (v_vld_q[2] && (v_tag_q[2] == LAST_IDX)) vout_q <= new_v;
  end

  // Output scaling: halve with floor, then clamp to Q1.15.
  assign vhalf = vout_q >>> 1;
  always_comb begin
    if ((&vhalf[DATA_W-1:SAMPLE_W-1]) || !(|vhalf[DATA_W-1:SAMPLE_W-1])) begin
      tap = vhalf[SAMPLE_W-1:0];
    end else if (vhalf[DATA_W-1]) begin
      tap = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      tap = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_tdata_q <= tap;
      m_tlast_q <= last_q;
    end
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;
  assign m_axis_tlast  = m_tlast_q;

  // The issue spacing must keep the two current-pass multiplies apart.
  a_mul_one_user: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(c_vld_q[0] && c_vld_q[3]))
    else $error("multiplier claimed by two current-pass stages");

  a_pass_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !((|c_vld_q) && (|v_vld_q)))
    else $error("current and voltage passes overlap");

  a_cur_no_rmw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (c_issue && c_vld_q[4]) |-> (rd_idx != c_tag_q[4]))
    else $error("current read hits the entry being written");

  a_volt_no_rmw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_issue && v_vld_q[2]) |-> (rd_idx != v_tag_q[2]))
    else $error("voltage read hits the entry being written");

  a_load_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == ST_DONE) |-> $past(v_vld_q[2] && (v_tag_q[2] == LAST_IDX), 2))
    else $error("result loaded before the last node was written");

endmodule
